>>> src/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: lbl");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> src/zyz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package zyz_pkg;

  localparam int CW = 40;   // cordic x/y width
  localparam int ZW = 34;   // cordic angle width, units pi/2^30
  localparam int SW = 36;   // sums of products
  localparam int RW = 18;   // rounded angles, units pi/16384

  localparam logic signed [ZW-1:0] PI_Z     = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] TWO_PI_Z = ZW'(64'sd2147483648);
  localparam logic signed [SW-1:0] ONE_Q28  = SW'(64'sd268435456);

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    q14_t ar;
    q14_t ai;
    q14_t br;
    q14_t bi;
    q14_t cr;
    q14_t ci;
    q14_t dr;
    q14_t di;
  } mat_t;

  typedef struct packed {
    logic                 bad;
    logic signed [SW-1:0] detr;
    logic signed [SW-1:0] deti;
    mat_t                 mat;
  } prep_t;

  typedef struct packed {
    logic                 not_unitary;
    logic signed [14:0]   global_phase;
    logic        [14:0]   theta;
    logic signed [16:0]   phi;
    logic signed [16:0]   lambda;
  } res_t;

  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd268435456;
      5'd1:  v = 30'd158466703;
      5'd2:  v = 30'd83729454;
      5'd3:  v = 30'd42502378;
      5'd4:  v = 30'd21333666;
      5'd5:  v = 30'd10677233;
      5'd6:  v = 30'd5339919;
      5'd7:  v = 30'd2670123;
      5'd8:  v = 30'd1335082;
      5'd9:  v = 30'd667543;
      5'd10: v = 30'd333772;
      5'd11: v = 30'd166886;
      5'd12: v = 30'd83443;
      5'd13: v = 30'd41722;
      5'd14: v = 30'd20861;
      5'd15: v = 30'd10430;
      5'd16: v = 30'd5215;
      5'd17: v = 30'd2608;
      5'd18: v = 30'd1304;
      5'd19: v = 30'd652;
      5'd20: v = 30'd326;
      5'd21: v = 30'd163;
      5'd22: v = 30'd81;
      5'd23: v = 30'd41;
      5'd24: v = 30'd20;
      5'd25: v = 30'd10;
      5'd26: v = 30'd5;
      5'd27: v = 30'd3;
      5'd28: v = 30'd1;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return signed'({{(ZW-30){1'b0}}, v});
  endfunction

  function automatic logic signed [RW-1:0] wrap14(input logic signed [RW-1:0] r);
    logic signed [RW-1:0] t;
    t = r;
    if (t <= -RW'(18'sd16384)) t = t + RW'(18'sd32768);
    if (t > RW'(18'sd16384)) t = t - RW'(18'sd32768);
    return t;
  endfunction

  function automatic logic signed [RW-1:0] round14(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] s;
    s = (z + ZW'(34'sd32768)) >>> 16;
    return wrap14(s[RW-1:0]);
  endfunction

endpackage
`default_nettype wire

>>> src/zyz_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module zyz_cordic import zyz_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] x_in,
  input  wire logic signed [CW-1:0] y_in,
  output logic signed [ZW-1:0]      z_out,
  output logic signed [CW-1:0]      mag_out
);

  localparam int N = (STEPS > 32) ? 32 : STEPS;

  logic signed [CW-1:0] xs [0:N];
  logic signed [CW-1:0] ys [0:N];
  logic signed [ZW-1:0] zs [0:N];
  logic                 zero [0:N];

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= (y_in < 0) ? -PI_Z : PI_Z;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_val(5'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_val(5'(i));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero[N]) begin
        z_out   <= '0;
        mag_out <= '0;
      end else begin
        mag_out <= xs[N];
        if (zs[N] > PI_Z) z_out <= zs[N] - TWO_PI_Z;
        else if (zs[N] <= -PI_Z) z_out <= zs[N] + TWO_PI_Z;
        else z_out <= zs[N];
      end
    end
  end

endmodule
`default_nettype wire

>>> src/zyz_prep.sv
`timescale 1ns / 1ps
`default_nettype none
module zyz_prep import zyz_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] tol,
  input  wire mat_t        mat,
  output prep_t            pr
);

  logic signed [31:0] prod [0:23];
  mat_t               mat_d;
  logic signed [SW-1:0] n0, n1, ipr, ipi, e0, e1;
  logic signed [SW-1:0] tol_q;
  logic                 bad_next;

  always_ff @(posedge clk) begin
    if (en) begin
      mat_d    <= mat;
      prod[0]  <= mat.ar * mat.ar;
      prod[1]  <= mat.ai * mat.ai;
      prod[2]  <= mat.cr * mat.cr;
      prod[3]  <= mat.ci * mat.ci;
      prod[4]  <= mat.br * mat.br;
      prod[5]  <= mat.bi * mat.bi;
      prod[6]  <= mat.dr * mat.dr;
      prod[7]  <= mat.di * mat.di;
      prod[8]  <= mat.ar * mat.br;
      prod[9]  <= mat.ai * mat.bi;
      prod[10] <= mat.cr * mat.dr;
      prod[11] <= mat.ci * mat.di;
      prod[12] <= mat.ar * mat.bi;
      prod[13] <= mat.ai * mat.br;
      prod[14] <= mat.cr * mat.di;
      prod[15] <= mat.ci * mat.dr;
      prod[16] <= mat.ar * mat.dr;
      prod[17] <= mat.ai * mat.di;
      prod[18] <= mat.br * mat.cr;
      prod[19] <= mat.bi * mat.ci;
      prod[20] <= mat.ar * mat.di;
      prod[21] <= mat.ai * mat.dr;
      prod[22] <= mat.br * mat.ci;
      prod[23] <= mat.bi * mat.cr;
    end
  end

  always_comb begin
    n0  = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(prod[3]);
    n1  = SW'(prod[4]) + SW'(prod[5]) + SW'(prod[6]) + SW'(prod[7]);
    ipr = SW'(prod[8]) + SW'(prod[9]) + SW'(prod[10]) + SW'(prod[11]);
    ipi = SW'(prod[12]) - SW'(prod[13]) + SW'(prod[14]) - SW'(prod[15]);
    e0  = n0 - ONE_Q28;
    e1  = n1 - ONE_Q28;
    tol_q = signed'({{(SW-28){1'b0}}, tol, 12'b0});
    bad_next = ((e0 < 0) ? -e0 : e0) > tol_q ||
               ((e1 < 0) ? -e1 : e1) > tol_q ||
               ((ipr < 0) ? -ipr : ipr) > tol_q ||
               ((ipi < 0) ? -ipi : ipi) > tol_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr.bad  <= bad_next;
      pr.detr <= (SW'(prod[16]) - SW'(prod[17])) - (SW'(prod[18]) - SW'(prod[19]));
      pr.deti <= (SW'(prod[20]) + SW'(prod[21])) - (SW'(prod[22]) + SW'(prod[23]));
      pr.mat  <= mat_d;
    end
  end

endmodule
`default_nettype wire

>>> src/zyz_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module zyz_merge import zyz_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic                 bad,
  input  wire logic signed [ZW-1:0] zt,
  input  wire logic signed [14:0]   phase,
  input  wire logic signed [RW-1:0] r10,
  input  wire logic signed [RW-1:0] r11,
  output res_t                      res
);

  logic signed [ZW-1:0] th;
  logic signed [RW-1:0] a, b;
  logic        [14:0]   th_c;

  always_comb begin
    th = (zt + ZW'(34'sd16384)) >>> 15;
    if (th < 0) th_c = '0;
    else if (th > ZW'(34'sd16384)) th_c = 15'd16384;
    else th_c = th[14:0];
    a = wrap14(r11 - RW'(phase));
    b = wrap14(r10 - RW'(phase));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.not_unitary <= bad;
      if (bad) begin
        res.global_phase <= '0;
        res.theta        <= '0;
        res.phi          <= '0;
        res.lambda       <= '0;
      end else begin
        res.global_phase <= phase;
        res.theta        <= th_c;
        res.phi          <= 17'(a + b);
        res.lambda       <= 17'(a - b);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/zyz_euler_angle_decomposition.sv
// zyz euler decomposition of a 2x2 complex matrix, fully pipelined
// throughput: one matrix per cycle while the pipeline is not halted, set by one
// cordic stage per iteration in every lane
// the pipeline halts only while the output skid register is occupied
// reset (synchronous, rst high) empties all valid flags and sets unitary_tolerance to 16
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module zyz_euler_angle_decomposition import zyz_pkg::*; #(
  parameter int DATA_WIDTH   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // config: unitary_tolerance
  input  wire logic                    cfg_wen,
  input  wire logic [15:0]             cfg_wdata,
  // input stream
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // fields from bit 0: m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im
  input  wire logic [8*DATA_WIDTH-1:0] s_tdata,
  // output stream
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // fields from bit 0: global_phase, theta, phi, lambda
  output logic [63:0]                  m_tdata,
  // fields from bit 0: not_unitary
  output logic [0:0]                   m_tuser
);

  localparam int N  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int L  = N + 2;          // registers along one cordic lane
  localparam int NV = 2 * L + 5;      // pipeline stages before the output register

  logic [15:0] tol;
  logic        en;
  logic [NV-1:0] vld;

  // input conversion to q2.14
  q14_t q [0:7];
  for (genvar k = 0; k < 8; k++) begin : g_q14
    if (DATA_WIDTH >= 16) begin : g_down
      logic signed [DATA_WIDTH-1:0] raw;
      assign raw  = signed'(s_tdata[k*DATA_WIDTH +: DATA_WIDTH]);
      assign q[k] = 16'(raw >>> (DATA_WIDTH - 16));
    end else begin : g_up
      assign q[k] = signed'({s_tdata[k*DATA_WIDTH +: DATA_WIDTH],
                             {(16-DATA_WIDTH){1'b0}}});
    end
  end

  mat_t  mat_s1;
  prep_t pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 16'd16;
    end else if (cfg_wen) begin
      tol <= cfg_wdata;
    end
  end

  // stage 1: register the converted matrix
  always_ff @(posedge clk) begin
    if (en) begin
      mat_s1 <= '{ar: q[0], ai: q[1], br: q[2], bi: q[3],
                  cr: q[4], ci: q[5], dr: q[6], di: q[7]};
    end
  end

  // stages 2-3: products, unitarity check, determinant
  zyz_prep u_prep (
    .clk (clk),
    .en  (en),
    .tol (tol),
    .mat (mat_s1),
    .pr  (pr)
  );

  // four angle lanes side by side: determinant, m00, m10, m11
  logic signed [ZW-1:0] z_det, z00, z10, z11, zt;
  logic signed [CW-1:0] mag_det, mag00, mag10, mag11, mag_t;

  zyz_cordic #(.STEPS(CORDIC_STEPS)) u_lane_det (
    .clk (clk), .en (en),
    .x_in (CW'(pr.detr)), .y_in (CW'(pr.deti)),
    .z_out (z_det), .mag_out (mag_det)
  );
  zyz_cordic #(.STEPS(CORDIC_STEPS)) u_lane_m00 (
    .clk (clk), .en (en),
    .x_in (CW'(pr.mat.ar) <<< 16), .y_in (CW'(pr.mat.ai) <<< 16),
    .z_out (z00), .mag_out (mag00)
  );
  zyz_cordic #(.STEPS(CORDIC_STEPS)) u_lane_m10 (
    .clk (clk), .en (en),
    .x_in (CW'(pr.mat.cr) <<< 16), .y_in (CW'(pr.mat.ci) <<< 16),
    .z_out (z10), .mag_out (mag10)
  );
  zyz_cordic #(.STEPS(CORDIC_STEPS)) u_lane_m11 (
    .clk (clk), .en (en),
    .x_in (CW'(pr.mat.dr) <<< 16), .y_in (CW'(pr.mat.di) <<< 16),
    .z_out (z11), .mag_out (mag11)
  );

  // unitarity flag follows the lanes
  logic bad_d [0:L-1];
  always_ff @(posedge clk) begin
    if (en) begin
      bad_d[0] <= pr.bad;
      for (int i = 1; i < L; i++) bad_d[i] <= bad_d[i-1];
    end
  end

  // merge step one: phase and rounded element angles, magnitudes to theta lane
  logic signed [ZW-1:0] ph_full;
  logic signed [14:0]   phase_m;
  logic signed [RW-1:0] r10_m, r11_m;
  logic                 bad_m;
  logic signed [CW-1:0] mx, my;

  assign ph_full = (z_det + ZW'(34'sd65536)) >>> 17;

  always_ff @(posedge clk) begin
    if (en) begin
      phase_m <= ph_full[14:0];
      r10_m   <= round14(z10);
      r11_m   <= round14(z11);
      bad_m   <= bad_d[L-1];
      mx      <= mag00;
      my      <= mag10;
    end
  end

  zyz_cordic #(.STEPS(CORDIC_STEPS)) u_lane_theta (
    .clk (clk), .en (en),
    .x_in (mx), .y_in (my),
    .z_out (zt), .mag_out (mag_t)
  );

  // side data waits for the theta lane
  logic signed [14:0]   phase_d [0:L-1];
  logic signed [RW-1:0] r10_d   [0:L-1];
  logic signed [RW-1:0] r11_d   [0:L-1];
  logic                 bad_t   [0:L-1];
  always_ff @(posedge clk) begin
    if (en) begin
      phase_d[0] <= phase_m;
      r10_d[0]   <= r10_m;
      r11_d[0]   <= r11_m;
      bad_t[0]   <= bad_m;
      for (int i = 1; i < L; i++) begin
        phase_d[i] <= phase_d[i-1];
        r10_d[i]   <= r10_d[i-1];
        r11_d[i]   <= r11_d[i-1];
        bad_t[i]   <= bad_t[i-1];
      end
    end
  end

  // merge step two: theta, phi, lambda
  res_t res;
  zyz_merge u_merge (
    .clk   (clk),
    .en    (en),
    .bad   (bad_t[L-1]),
    .zt    (zt),
    .phase (phase_d[L-1]),
    .r10   (r10_d[L-1]),
    .r11   (r11_d[L-1]),
    .res   (res)
  );

  // beat valid flags ride alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], s_tvalid};
    end
  end

  // output register plus skid register
  res_t out_r, skid_r;
  logic skid_valid;
  logic out_take;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign out_take = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_r      <= skid_r;
        skid_valid <= 1'b0;
      end
    end else if (vld[NV-1]) begin
      if (!m_tvalid || out_take) begin
        out_r    <= res;
        m_tvalid <= 1'b1;
      end else begin
        skid_r     <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      m_tvalid <= 1'b0;
    end
  end

  // unused magnitudes of the determinant, m11 and theta lanes are left open by design
  logic unused_mag;
  assign unused_mag = ^{mag_det, mag11, mag_t};

  assign m_tdata = {out_r.lambda, out_r.phi, out_r.theta, out_r.global_phase};
  assign m_tuser = out_r.not_unitary;

  `ASSERT_IMPLY(a_skid_has_out, clk, rst, skid_valid, m_tvalid)
  `ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && !m_tready, skid_valid)
  `ASSERT_IMPLY(a_bad_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == 64'd0)
  `ASSERT_IMPLY(a_theta_range, clk, rst, m_tvalid, m_tdata[29:15] <= 15'd16384)

endmodule
`default_nettype wire

>>> dv/zyz_euler_angle_decomposition_checker.sv
`timescale 1ns / 1ps
module zyz_euler_angle_decomposition_checker import zyz_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [0:0]   m_tuser,
  output int           errors,
  output int           pending,
  output int           angle_count,
  output int           reject_count
);
  typedef struct {
    logic               not_unitary;
    logic signed [14:0] global_phase;
    logic [14:0]        theta;
    logic signed [16:0] phi;
    logic signed [16:0] lambda;
  } angles_t;

  angles_t angle_queue[$];
  longint tolerance;

  localparam longint HALF_TURN = 64'sd1 << 30;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // cordic vectoring, angle in pi/2^30, magnitude carries gain
  function automatic longint vector_angle(longint x, longint y, output longint mag);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y < 0) ? -HALF_TURN : HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_val(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_val(5'(i)));
      end
    end
    if (z > HALF_TURN) z -= 2 * HALF_TURN;
    if (z <= -HALF_TURN) z += 2 * HALF_TURN;
    mag = x;
    return z;
  endfunction

  function automatic longint wrap_turn(longint r);
    if (r <= -16384) r += 32768;
    if (r > 16384) r -= 32768;
    return r;
  endfunction

  function automatic angles_t decompose(logic [127:0] d, longint tol_q12);
    longint ar, ai, br, bi, cr, ci, dr, di, n0, n1, ipr, ipi, detr, deti;
    longint zdet, mg, m00, m10, z10, z11, zt, ph, th, a, b, tol;
    angles_t r;
    ar = longint'($signed(d[15:0]));    ai = longint'($signed(d[31:16]));
    br = longint'($signed(d[47:32]));   bi = longint'($signed(d[63:48]));
    cr = longint'($signed(d[79:64]));   ci = longint'($signed(d[95:80]));
    dr = longint'($signed(d[111:96]));  di = longint'($signed(d[127:112]));
    tol = tol_q12 << 12;
    r = '{1'b0, '0, '0, '0, '0};
    n0 = ar*ar + ai*ai + cr*cr + ci*ci;
    n1 = br*br + bi*bi + dr*dr + di*di;
    ipr = ar*br + ai*bi + cr*dr + ci*di;
    ipi = ar*bi - ai*br + cr*di - ci*dr;
    if ((n0 - (64'sd1 << 28) > tol) || ((64'sd1 << 28) - n0 > tol) ||
        (n1 - (64'sd1 << 28) > tol) || ((64'sd1 << 28) - n1 > tol) ||
        ipr > tol || -ipr > tol || ipi > tol || -ipi > tol) begin
      r.not_unitary = 1'b1;
      return r;
    end
    detr = (ar*dr - ai*di) - (br*cr - bi*ci);
    deti = (ar*di + ai*dr) - (br*ci + bi*cr);
    zdet = vector_angle(detr, deti, mg);
    ph = floor_shift(zdet + 65536, 17);
    void'(vector_angle(ar * 65536, ai * 65536, m00));
    z10 = vector_angle(cr * 65536, ci * 65536, m10);
    z11 = vector_angle(dr * 65536, di * 65536, mg);
    zt = vector_angle(m00, m10, mg);
    th = floor_shift(zt + 16384, 15);
    if (th < 0) th = 0;
    if (th > 16384) th = 16384;
    a = wrap_turn(wrap_turn(floor_shift(z11 + 32768, 16)) - ph);
    b = wrap_turn(wrap_turn(floor_shift(z10 + 32768, 16)) - ph);
    r.global_phase = 15'(ph);
    r.theta = 15'(th);
    r.phi = 17'(a + b);
    r.lambda = 17'(a - b);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = angle_queue.size();

  initial begin
    errors = 0; angle_count = 0; reject_count = 0; tolerance = 16;
  end

  always @(posedge clk) begin
    angles_t want;
    if (rst) begin
      tolerance = 16;
    end else begin
      if (cfg_wen) tolerance = cfg_wdata;
      if (s_tvalid && s_tready) angle_queue.push_back(decompose(s_tdata, tolerance));
      if (m_tvalid && m_tready) begin
        if (angle_queue.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = angle_queue.pop_front();
          if (want.not_unitary) reject_count++; else angle_count++;
          if (m_tuser[0] !== want.not_unitary)
            report_mismatch("not_unitary", m_tuser[0], want.not_unitary);
          if (m_tdata[14:0] !== want.global_phase)
            report_mismatch("global_phase", $signed(m_tdata[14:0]), want.global_phase);
          if (m_tdata[29:15] !== want.theta)
            report_mismatch("theta", m_tdata[29:15], want.theta);
          if (m_tdata[46:30] !== want.phi)
            report_mismatch("phi", $signed(m_tdata[46:30]), want.phi);
          if (m_tdata[63:47] !== want.lambda)
            report_mismatch("lambda", $signed(m_tdata[63:47]), want.lambda);
        end
      end
    end
  end
endmodule

>>> dv/zyz_euler_angle_decomposition_tb.sv
`timescale 1ns / 1ps
module zyz_euler_angle_decomposition_tb;
  import zyz_pkg::*;

  localparam int LATENCY = 2 * 16 + 10;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk, rst;
  logic         cfg_wen;
  logic [15:0]  cfg_wdata;
  logic         s_tvalid, s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid, m_tready;
  logic [63:0]  m_tdata;
  logic [0:0]   m_tuser;
  int           errors, pending, angle_count, reject_count;
  int           cycles;
  int           sent;
  bit           calm;       // no idling on either side near the end
  bit           hold_off;   // receiver parked for a long stretch

  zyz_euler_angle_decomposition dut (
    .clk, .rst, .cfg_wen, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  zyz_euler_angle_decomposition_checker checker_i (
    .clk, .rst, .cfg_wen, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .errors, .pending, .angle_count, .reject_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("[zyz_euler_angle_decomposition] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, long hold-off when asked
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 16);
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // complex of magnitude amp from an angle in radians, scaled to q14
  function automatic logic [31:0] unit_cplx(real ang, real amp);
    logic signed [15:0] re, im;
    re = 16'($rtoi($floor(amp * 16384.0 * $cos(ang) + 0.5)));
    im = 16'($rtoi($floor(amp * 16384.0 * $sin(ang) + 0.5)));
    return {im, re};
  endfunction

  // u = e^{i g} [[e^{-i(p+l)/2} c, -e^{-i(p-l)/2} s], [e^{i(p-l)/2} s, e^{i(p+l)/2} c]]
  function automatic logic [127:0] make_unitary(real g, real th, real p, real l);
    real c, s;
    logic [31:0] m00, m01, m10, m11;
    c = $cos(th / 2.0);
    s = $sin(th / 2.0);
    m00 = unit_cplx(g - (p + l) / 2.0, c);
    m01 = unit_cplx(g - (p - l) / 2.0 + 3.14159265358979, s);
    m10 = unit_cplx(g + (p - l) / 2.0, s);
    m11 = unit_cplx(g + (p + l) / 2.0, c);
    return {m11, m10, m01, m00};
  endfunction

  function automatic real rand_angle();
    return ($urandom_range(0, 65535) / 32768.0 - 1.0) * 3.14159265358979;
  endfunction

  function automatic logic [127:0] random_item();
    logic [127:0] d;
    int pick;
    real th;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      th = $urandom_range(0, 65535) / 65535.0 * 3.14159265358979;
      // snap some thetas onto the edges
      if (pick < 6) th = 0.0;
      else if (pick < 12) th = 3.14159265358979;
      d = make_unitary(rand_angle(), th, rand_angle(), rand_angle());
    end else if (pick < 85) begin
      d = make_unitary(rand_angle(), rand_angle() + 3.2, rand_angle(), rand_angle());
      d[$urandom_range(0, 127)] ^= 1'b1;  // nudge one bit
    end else begin
      d = {$urandom, $urandom, $urandom, $urandom};
    end
    return d;
  endfunction

  task automatic send(logic [127:0] d);
    s_tdata  <= d;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic source_gap();
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  // wait until everything is out and the pipe is empty, then write the register
  task automatic set_tolerance(logic [15:0] v);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    logic [15:0] tol_steps[4];
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    sent = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: identity, pauli-like, zero matrix, extremes, -pi landings
    send(make_unitary(0.0, 0.0, 0.0, 0.0));
    send({16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    send({16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    send({16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384});
    send({16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0});
    send({16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    send('0);
    send({8{16'h8000}});
    send({8{16'h7fff}});
    send({8{16'hffff}});
    send(make_unitary(3.14159265358979 / 2.0, 1.0, 3.14159265358979, 3.14159265358979));
    send(make_unitary(-3.14159265358979 / 2.0, 2.0, -3.0, 3.0));
    send(make_unitary(0.3, 3.14159265358979, 1.0, -2.0));
    send(make_unitary(-1.2, 0.0, 2.5, 0.7));

    tol_steps = '{16'd0, 16'd65535, 16'd200, 16'd16};
    for (int phase_i = 0; phase_i < 4; phase_i++) begin
      set_tolerance(tol_steps[phase_i]);
      for (int k = 0; k < 200; k++) begin
        send(random_item());
        source_gap();
      end
    end

    // receiver parks while the sender keeps pushing, the pipe backs up
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 80; k++) send(random_item());
    join

    // sender drains out completely before the last burst
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);

    calm = 1'b1;
    for (int k = 0; k < 120; k++) send(random_item());
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    $display("sent %0d matrices: %0d decomposed, %0d rejected as non-unitary",
             sent, angle_count, reject_count);
    $display("tolerance swept over 0, 65535, 200 and 16 with stalls on both sides");
    if (errors == 0) begin
      $display("[zyz_euler_angle_decomposition] OK");
    end else begin
      $display("[zyz_euler_angle_decomposition] ERROR");
    end
    $finish;
  end
endmodule
